// File: src/anagram_window_search_unit_macros.svh
`ifndef ANAGRAM_WINDOW_SEARCH_UNIT_MACROS_SVH
`define ANAGRAM_WINDOW_SEARCH_UNIT_MACROS_SVH

// same-cycle implication
`define AWSU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AWSU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/awsu_pkg.sv
package awsu_pkg;

    localparam int SYM_W      = 8;
    localparam int SYM_NUM    = 256;
    localparam int NZ_W       = 9;
    localparam int REQ_W      = 2;
    localparam int POSITION_W = 16;

    localparam logic [REQ_W-1:0] REQ_CLEAR   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PATTERN = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TEXT    = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_TXT,
        S_WIN,
        S_PAT
    } t_state;

    // one +1/-1 update of a difference table entry
    typedef struct packed {
        logic             valid;
        logic [SYM_W-1:0] sym;
        logic             inc;
    } t_adj;

    typedef struct packed {
        logic            busy;
        logic [NZ_W-1:0] nonzero_next;
    } t_tbl_stat;

endpackage

// File: src/awsu_ram.sv
module awsu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old word on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/awsu_diff_table.sv
`include "anagram_window_search_unit_macros.svh"

module awsu_diff_table #(
    parameter int MAX_PAT = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  awsu_pkg::t_adj       i_adj,
    output awsu_pkg::t_tbl_stat  o_stat
);

    localparam int DW = $clog2(MAX_PAT + 1) + 1;
    localparam int NZ_W = awsu_pkg::NZ_W;
    localparam int SYM_W = awsu_pkg::SYM_W;

    awsu_pkg::t_adj     r_stg;
    logic               r_clearing;
    logic [SYM_W-1:0]   r_clr_cnt;
    logic               r_lw_v;
    logic [SYM_W-1:0]   r_lw_sym;
    logic [DW-1:0]      r_lw_data;
    logic [NZ_W-1:0]    r_nonzero;

    logic [DW-1:0]      ram_rdata;
    logic               c_we;
    logic [SYM_W-1:0]   c_waddr;
    logic [DW-1:0]      c_wdata;
    logic [DW-1:0]      c_old;
    logic [DW-1:0]      c_new;
    logic [NZ_W-1:0]    c_nz_next;

    awsu_ram #(
        .WIDTH (DW),
        .DEPTH (awsu_pkg::SYM_NUM)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (c_wdata),
        .i_raddr (i_adj.sym),
        .o_rdata (ram_rdata)
    );

    // forward the last write when the same symbol comes back to back
    always_comb begin
        c_old = (r_lw_v && (r_lw_sym == r_stg.sym)) ? r_lw_data : ram_rdata;
        c_new = r_stg.inc ? c_old + DW'(1) : c_old - DW'(1);
        c_nz_next = r_nonzero;
        if (r_stg.valid) begin
            if (c_old == '0) begin
                c_nz_next = r_nonzero + NZ_W'(1);
            end else if (c_new == '0) begin
                c_nz_next = r_nonzero - NZ_W'(1);
            end
        end
        if (r_clearing) begin
            c_we    = 1'b1;
            c_waddr = r_clr_cnt;
            c_wdata = '0;
        end else begin
            c_we    = r_stg.valid;
            c_waddr = r_stg.sym;
            c_wdata = c_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg      <= '0;
            r_clearing <= 1'b1;
            r_clr_cnt  <= '0;
            r_lw_v     <= 1'b0;
            r_nonzero  <= '0;
        end else begin
            r_stg     <= i_adj;
            r_nonzero <= c_nz_next;
            if (r_clearing) begin
                r_clr_cnt <= r_clr_cnt + SYM_W'(1);
                if (r_clr_cnt == SYM_W'(awsu_pkg::SYM_NUM - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            if (r_stg.valid) begin
                r_lw_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_stg.valid) begin
            r_lw_sym  <= r_stg.sym;
            r_lw_data <= c_new;
        end
    end

    assign o_stat.busy         = r_clearing;
    assign o_stat.nonzero_next = c_nz_next;

    `AWSU_ASSERT_IMP(a_no_adj_in_clear, i_clk, i_rst_n, r_clearing, !i_adj.valid, "update during clear")
    `AWSU_ASSERT_IMP(a_nz_range, i_clk, i_rst_n, !r_clearing, c_nz_next <= NZ_W'(awsu_pkg::SYM_NUM), "nonzero count out of range")

endmodule

// File: src/anagram_window_search_unit.sv
// channel | valid   | stall   | payload
// in      | i_valid | o_stall | i_req_type, i_ch, i_last
// out     | o_valid | i_stall | o_found, o_position, o_overflow
// With a full window a text byte first reads the outgoing symbol from the ring.
// A pattern byte walks the current window back out of the table.
//   A last text byte also walks its window back out once its result is registered.
//   A clear walks the window out as a pattern byte does, then walks the pattern out.
// After reset the 256-entry difference table is swept to zero: requests stall until the sweep ends.
// The result sits in an output register; only a last text byte waits on a stalled result.
`include "anagram_window_search_unit_macros.svh"

module anagram_window_search_unit #(
    parameter int MAX_PAT  = 16,
    parameter int POS_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [awsu_pkg::REQ_W-1:0]          i_req_type,
    input  logic [awsu_pkg::SYM_W-1:0]          i_ch,
    input  logic                                i_last,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_found,
    output logic [awsu_pkg::POSITION_W-1:0]     o_position,
    output logic                                o_overflow
);

    localparam int PW = (MAX_PAT > 1) ? $clog2(MAX_PAT) : 1;
    localparam int LW = $clog2(MAX_PAT + 1);
    localparam int TW = POS_BITS + 1;
    localparam int SYM_W = awsu_pkg::SYM_W;
    localparam int POSITION_W = awsu_pkg::POSITION_W;
    localparam logic [LW-1:0] LEN_MAX  = LW'(MAX_PAT);
    localparam logic [PW-1:0] PTR_LAST = PW'(MAX_PAT - 1);

    awsu_pkg::t_state    r_state, n_state;
    logic [LW-1:0]       r_len, n_len;
    logic                r_pat_over, n_pat_over;
    logic [TW-1:0]       r_tp, n_tp;
    logic [PW-1:0]       r_ring_ptr, n_ring_ptr;
    logic                r_match, n_match;
    logic [POS_BITS-1:0] r_mpos, n_mpos;
    logic                r_tovf, n_tovf;
    logic                r_last, n_last;
    logic [PW-1:0]       r_walk_ptr, n_walk_ptr;
    logic [LW-1:0]       r_walk_cnt, n_walk_cnt;
    logic                r_then_pat, n_then_pat;
    logic                r_rd_pend, n_rd_pend;
    logic                r_rd_src, n_rd_src;
    logic                r_rd_inc, n_rd_inc;
    logic                r_ovalid, n_ovalid;
    logic                r_ofound, n_ofound;
    logic [POSITION_W-1:0] r_opos, n_opos;
    logic                r_oovf, n_oovf;

    awsu_pkg::t_adj      adj;
    awsu_pkg::t_tbl_stat tbl_stat;
    logic [SYM_W-1:0]    ring_rdata;
    logic [SYM_W-1:0]    pat_rdata;

    logic                c_accept;
    logic                c_direct_v;
    logic                c_direct_inc;
    logic                c_ring_we;
    logic                c_pat_we;
    logic [PW-1:0]       c_ring_raddr;
    logic [PW-1:0]       c_ring_next;
    logic [PW-1:0]       c_walk_prev;
    logic [LW:0]         c_ptr_ext;
    logic [LW:0]         c_len_ext;
    logic [LW:0]         c_old_full;
    logic [PW-1:0]       c_old_slot;
    logic [TW-1:0]       c_tp_inc;
    logic [TW-1:0]       c_tp_after;
    logic [LW-1:0]       c_win_now;
    logic [LW-1:0]       c_win_after;
    logic                c_beyond;
    logic                c_hit;
    logic                c_match_n;
    logic [POS_BITS-1:0] c_mpos_n;
    logic [31:0]         c_pos_wide;
    logic                c_tovf_n;

    awsu_diff_table #(
        .MAX_PAT (MAX_PAT)
    ) u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adj   (adj),
        .o_stat  (tbl_stat)
    );

    awsu_ram #(
        .WIDTH (SYM_W),
        .DEPTH (MAX_PAT)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (c_ring_we),
        .i_waddr (r_ring_ptr),
        .i_wdata (i_ch),
        .i_raddr (c_ring_raddr),
        .o_rdata (ring_rdata)
    );

    awsu_ram #(
        .WIDTH (SYM_W),
        .DEPTH (MAX_PAT)
    ) u_pattern (
        .i_clk   (i_clk),
        .i_we    (c_pat_we),
        .i_waddr (r_len[PW-1:0]),
        .i_wdata (i_ch),
        .i_raddr (r_walk_ptr),
        .o_rdata (pat_rdata)
    );

    assign o_stall  = (r_state != awsu_pkg::S_IDLE) || tbl_stat.busy;
    assign c_accept = i_valid && !o_stall;

    // ring slot of the symbol leaving the window
    always_comb begin
        c_ptr_ext  = (LW + 1)'(r_ring_ptr);
        c_len_ext  = (LW + 1)'(r_len);
        c_old_full = (c_ptr_ext >= c_len_ext) ? c_ptr_ext - c_len_ext
                                              : c_ptr_ext + (LW + 1)'(MAX_PAT) - c_len_ext;
        c_old_slot = c_old_full[PW-1:0];
    end

    always_comb begin
        c_ring_next = (r_ring_ptr == PTR_LAST) ? '0 : r_ring_ptr + PW'(1);
        c_walk_prev = (r_walk_ptr == '0) ? PTR_LAST : r_walk_ptr - PW'(1);
        c_tp_inc    = r_tp + TW'(1);
        c_beyond    = r_tp[POS_BITS];
        c_tp_after  = c_beyond ? r_tp : c_tp_inc;
        c_win_now   = (r_tp >= TW'(r_len)) ? r_len : r_tp[LW-1:0];
        c_win_after = (c_tp_after >= TW'(r_len)) ? r_len : c_tp_after[LW-1:0];
        c_hit       = (r_len == '0) ||
                      ((c_tp_inc >= TW'(r_len)) && (tbl_stat.nonzero_next == '0));
        c_match_n   = r_match || c_hit;
        if (r_match) begin
            c_mpos_n = r_mpos;
        end else if (r_len == '0 || !c_hit) begin
            c_mpos_n = '0;
        end else if (c_beyond) begin
            c_mpos_n = '1;
        end else begin
            c_mpos_n = POS_BITS'(c_tp_inc - TW'(r_len));
        end
        c_pos_wide  = 32'(c_mpos_n);
        c_tovf_n    = r_tovf || c_beyond;
    end

    // pending reads feed the registered ring or pattern read word to the table
    always_comb begin
        adj.valid = r_rd_pend || c_direct_v;
        adj.sym   = r_rd_pend ? (r_rd_src ? pat_rdata : ring_rdata) : i_ch;
        adj.inc   = r_rd_pend ? r_rd_inc : c_direct_inc;
    end

    always_comb begin
        n_state      = r_state;
        n_len        = r_len;
        n_pat_over   = r_pat_over;
        n_tp         = r_tp;
        n_ring_ptr   = r_ring_ptr;
        n_match      = r_match;
        n_mpos       = r_mpos;
        n_tovf       = r_tovf;
        n_last       = r_last;
        n_walk_ptr   = r_walk_ptr;
        n_walk_cnt   = r_walk_cnt;
        n_then_pat   = r_then_pat;
        n_rd_pend    = 1'b0;
        n_rd_src     = r_rd_src;
        n_rd_inc     = r_rd_inc;
        n_ovalid     = r_ovalid && i_stall;
        n_ofound     = r_ofound;
        n_opos       = r_opos;
        n_oovf       = r_oovf;
        c_direct_v   = 1'b0;
        c_direct_inc = 1'b0;
        c_ring_we    = 1'b0;
        c_pat_we     = 1'b0;
        c_ring_raddr = c_old_slot;

        unique case (r_state)
            awsu_pkg::S_IDLE: begin
                if (c_accept) begin
                    unique case (i_req_type)
                        awsu_pkg::REQ_CLEAR: begin
                            n_walk_ptr = r_ring_ptr;
                            n_walk_cnt = c_win_now;
                            n_then_pat = 1'b1;
                            n_tp       = '0;
                            n_ring_ptr = '0;
                            n_match    = 1'b0;
                            n_mpos     = '0;
                            n_tovf     = 1'b0;
                            n_state    = awsu_pkg::S_WIN;
                        end
                        awsu_pkg::REQ_PATTERN: begin
                            n_walk_ptr = r_ring_ptr;
                            n_walk_cnt = c_win_now;
                            n_then_pat = 1'b0;
                            n_tp       = '0;
                            n_ring_ptr = '0;
                            n_match    = 1'b0;
                            n_mpos     = '0;
                            n_tovf     = 1'b0;
                            if (r_len != LEN_MAX) begin
                                c_pat_we     = 1'b1;
                                c_direct_v   = 1'b1;
                                c_direct_inc = 1'b1;
                                n_len        = r_len + LW'(1);
                            end else begin
                                n_pat_over = 1'b1;
                            end
                            n_state = awsu_pkg::S_WIN;
                        end
                        awsu_pkg::REQ_TEXT: begin
                            n_last = i_last;
                            if (r_len != '0) begin
                                c_ring_we    = 1'b1;
                                n_ring_ptr   = c_ring_next;
                                c_direct_v   = 1'b1;
                                c_direct_inc = 1'b0;
                                if (r_tp >= TW'(r_len)) begin
                                    n_rd_pend = 1'b1;
                                    n_rd_src  = 1'b0;
                                    n_rd_inc  = 1'b1;
                                end
                            end
                            n_state = awsu_pkg::S_TXT;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            awsu_pkg::S_TXT: begin
                if (!r_rd_pend) begin
                    if (!r_last) begin
                        n_match = c_match_n;
                        n_mpos  = c_mpos_n;
                        n_tovf  = c_tovf_n;
                        n_tp    = c_tp_after;
                        n_state = awsu_pkg::S_IDLE;
                    end else if (!r_ovalid || !i_stall) begin
                        n_ovalid   = 1'b1;
                        n_ofound   = c_match_n;
                        n_opos     = c_pos_wide[POSITION_W-1:0];
                        n_oovf     = c_tovf_n || r_pat_over;
                        n_walk_ptr = r_ring_ptr;
                        n_walk_cnt = c_win_after;
                        n_then_pat = 1'b0;
                        n_tp       = '0;
                        n_ring_ptr = '0;
                        n_match    = 1'b0;
                        n_mpos     = '0;
                        n_tovf     = 1'b0;
                        n_state    = awsu_pkg::S_WIN;
                    end
                end
            end
            awsu_pkg::S_WIN: begin
                c_ring_raddr = c_walk_prev;
                if (r_walk_cnt != '0) begin
                    n_walk_ptr = c_walk_prev;
                    n_walk_cnt = r_walk_cnt - LW'(1);
                    n_rd_pend  = 1'b1;
                    n_rd_src   = 1'b0;
                    n_rd_inc   = 1'b1;
                end else if (!r_rd_pend) begin
                    if (r_then_pat) begin
                        n_walk_ptr = '0;
                        n_walk_cnt = r_len;
                        n_len      = '0;
                        n_pat_over = 1'b0;
                        n_state    = awsu_pkg::S_PAT;
                    end else begin
                        n_state = awsu_pkg::S_IDLE;
                    end
                end
            end
            awsu_pkg::S_PAT: begin
                if (r_walk_cnt != '0) begin
                    n_walk_ptr = r_walk_ptr + PW'(1);
                    n_walk_cnt = r_walk_cnt - LW'(1);
                    n_rd_pend  = 1'b1;
                    n_rd_src   = 1'b1;
                    n_rd_inc   = 1'b0;
                end else if (!r_rd_pend) begin
                    n_state = awsu_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = awsu_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= awsu_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= '0;
            r_pat_over <= 1'b0;
            r_tp       <= '0;
            r_ring_ptr <= '0;
            r_match    <= 1'b0;
            r_mpos     <= '0;
            r_tovf     <= 1'b0;
            r_walk_cnt <= '0;
            r_then_pat <= 1'b0;
            r_rd_pend  <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            r_len      <= n_len;
            r_pat_over <= n_pat_over;
            r_tp       <= n_tp;
            r_ring_ptr <= n_ring_ptr;
            r_match    <= n_match;
            r_mpos     <= n_mpos;
            r_tovf     <= n_tovf;
            r_walk_cnt <= n_walk_cnt;
            r_then_pat <= n_then_pat;
            r_rd_pend  <= n_rd_pend;
            r_ovalid   <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last     <= n_last;
        r_walk_ptr <= n_walk_ptr;
        r_rd_src   <= n_rd_src;
        r_rd_inc   <= n_rd_inc;
        r_ofound   <= n_ofound;
        r_opos     <= n_opos;
        r_oovf     <= n_oovf;
    end

    assign o_valid    = r_ovalid;
    assign o_found    = r_ofound;
    assign o_position = r_opos;
    assign o_overflow = r_oovf;

    `AWSU_ASSERT_IMP(a_pend_not_idle, i_clk, i_rst_n, r_rd_pend, r_state != awsu_pkg::S_IDLE, "pending read in idle")
    `AWSU_ASSERT_IMP(a_len_range, i_clk, i_rst_n, 1'b1, r_len <= LEN_MAX, "pattern length out of range")
    `AWSU_ASSERT_NXT(a_result_held, i_clk, i_rst_n, (r_state == awsu_pkg::S_TXT) && !r_rd_pend && r_last && r_ovalid && i_stall, r_state == awsu_pkg::S_TXT, "result overwritten")
    `AWSU_ASSERT_IMP(a_pos_zero, i_clk, i_rst_n, r_ovalid && !r_ofound, r_opos == '0, "position set without match")

endmodule
